// ===== rtl/csr_pkg.sv =====
// shared types and constants of the can segment reassembler
// no dependencies
`timescale 1ns / 1ps

package csr_pkg;

  localparam int unsigned MaxMessage = 256;
  localparam int unsigned CntW       = 9;
  localparam int unsigned NumPayload = 7;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned JobDepth   = 2;
  localparam int unsigned JobPtrW    = 1;
  localparam int unsigned JobCntW    = 2;

  localparam logic [4:0]      SeqFinal  = 5'd31;
  localparam logic [CntW-1:0] LimitMax  = CntW'(MaxMessage);
  localparam logic [CntW-1:0] LimitMin  = CntW'(1);

  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_LENGTH = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BUDGET = 3'd3,
    ST_SEQ    = 3'd4
  } status_e;

  typedef logic [NumPayload-1:0][7:0] payload_t;

  typedef struct packed {
    logic            is_err;
    status_e         status;
    logic [CntW-1:0] base;
    logic [IdxW-1:0] size;
    logic            done;
    payload_t        data;
  } job_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [7:0]      byte_offset;
    status_e         status;
    logic            last_of_frame;
    logic            message_done;
    logic [CntW-1:0] total_bytes;
  } result_t;

endpackage

// ===== rtl/csr_front.sv =====
// front end: frame checks, message state and budget register
// depends on csr_pkg
`timescale 1ns / 1ps

module csr_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [csr_pkg::CntW-1:0] cfg_data_i,
  input  logic                    accept_i,
  input  logic [3:0]              length_code_i,
  input  logic [7:0]              header_byte_i,
  input  csr_pkg::payload_t       payload_i,
  output csr_pkg::job_t           job_o
);
  import csr_pkg::*;

  logic [CntW-1:0] limit_cfg_q;
  logic [4:0]      exp_seq_q, exp_seq_d;
  logic [CntW-1:0] bytes_q, bytes_d;

  logic [IdxW-1:0] size;
  logic [4:0]      seq;
  logic [CntW-1:0] limit;
  logic [CntW-1:0] remaining;
  logic [CntW:0]   sum;
  logic            len_bad, empty_bad, budget_bad, seq_bad, done;

  assign size = header_byte_i[2:0];
  assign seq  = header_byte_i[7:3];

  always_comb begin
    if (limit_cfg_q < LimitMin) begin
      limit = LimitMin;
    end else if (limit_cfg_q > LimitMax) begin
      limit = LimitMax;
    end else begin
      limit = limit_cfg_q;
    end
  end

  assign remaining  = (bytes_q < limit) ? (limit - bytes_q) : '0;
  assign sum        = {1'b0, bytes_q} + (CntW+1)'(size);
  assign len_bad    = (length_code_i != ({1'b0, size} + 4'd1));
  assign empty_bad  = (size == '0);
  assign budget_bad = (remaining < CntW'(size));
  assign seq_bad    = (seq != exp_seq_q) && (seq != SeqFinal);
  assign done       = (seq == SeqFinal) || (sum == {1'b0, limit});

  always_comb begin
    job_o.is_err = 1'b1;
    job_o.base   = bytes_q;
    job_o.size   = size;
    job_o.done   = 1'b1;
    job_o.data   = payload_i;
    if (len_bad) begin
      job_o.status = ST_LENGTH;
    end else if (empty_bad) begin
      job_o.status = ST_EMPTY;
    end else if (budget_bad) begin
      job_o.status = ST_BUDGET;
    end else if (seq_bad) begin
      job_o.status = ST_SEQ;
    end else begin
      job_o.status = ST_DATA;
      job_o.is_err = 1'b0;
      job_o.done   = done;
    end
  end

  always_comb begin
    exp_seq_d = exp_seq_q;
    bytes_d   = bytes_q;
    if (accept_i) begin
      if (job_o.done) begin
        exp_seq_d = '0;
        bytes_d   = '0;
      end else begin
        bytes_d = sum[CntW-1:0];
        if (exp_seq_q != SeqFinal) begin
          exp_seq_d = exp_seq_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_cfg_q <= LimitMax;
      exp_seq_q   <= '0;
      bytes_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_cfg_q <= cfg_data_i;
      end
      exp_seq_q <= exp_seq_d;
      bytes_q   <= bytes_d;
    end
  end

endmodule

// ===== rtl/csr_queue.sv =====
// short job queue between front end and byte emitter
// depends on csr_pkg
`timescale 1ns / 1ps

module csr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  csr_pkg::job_t wr_job_i,
  output logic          full_o,
  input  logic          rd_i,
  output csr_pkg::job_t rd_job_o,
  output logic          empty_o
);
  import csr_pkg::*;

  job_t               mem_q [JobDepth];
  logic [JobPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JobCntW-1:0] cnt_q;
  logic               do_wr, do_rd;

  assign full_o   = (cnt_q == JobCntW'(JobDepth));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + JobPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + JobPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + JobCntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - JobCntW'(1);
      end
    end
  end

endmodule

// ===== rtl/csr_back.sv =====
// back end: walks one job per frame and emits one result per cycle while its output register is free or popped
// depends on csr_pkg
`timescale 1ns / 1ps

module csr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  csr_pkg::job_t    job_i,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output csr_pkg::result_t res_o
);
  import csr_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q;
  result_t         res_q, res_d;
  logic            load, last;
  logic [CntW-1:0] off;

  assign load = !job_empty_i && (!out_valid_q || pop_i);
  assign last = job_i.is_err || (idx_q == job_i.size - IdxW'(1));
  assign off  = job_i.base + CntW'(idx_q);

  always_comb begin
    res_d.status        = job_i.status;
    res_d.last_of_frame = last;
    res_d.message_done  = last && job_i.done;
    if (job_i.is_err) begin
      res_d.data_byte   = '0;
      res_d.byte_offset = '0;
      res_d.total_bytes = job_i.base;
    end else begin
      res_d.data_byte   = job_i.data[idx_q];
      res_d.byte_offset = off[7:0];
      res_d.total_bytes = off + CntW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? '0 : idx_q + IdxW'(1);
    end
  end

  assign job_pop_o = load && last;
  assign empty_o   = !out_valid_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/can_segment_reassembler.sv =====
// top level of the can segment reassembler: front end, job queue, back end
// depends on csr_pkg, csr_front, csr_queue, csr_back
//
//   channel   direction  handshake               payload
//   frame     in         push_i / full_o         length_code_i, header_byte_i, payload_*_i
//   result    out        pop_i / empty_o         data_byte_o .. total_bytes_o
//   config    in         cfg_valid_i/cfg_ready_o cfg_data_i (message_limit)
//
// the front end takes one frame per cycle while the two-entry job queue has room
// the back end emits one result per cycle while its output register is free or popped:
// one per payload byte (1 to 7), or one for an error frame, in the single result register
// a result waiting in the output register does not stop the queue from filling
// reset clears message state, queue and output valid flag; budget returns to 256
`timescale 1ns / 1ps

module can_segment_reassembler (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i,
  input  logic       push_i,
  output logic       full_o,
  input  logic [3:0] length_code_i,
  input  logic [7:0] header_byte_i,
  input  logic [7:0] payload_0_i,
  input  logic [7:0] payload_1_i,
  input  logic [7:0] payload_2_i,
  input  logic [7:0] payload_3_i,
  input  logic [7:0] payload_4_i,
  input  logic [7:0] payload_5_i,
  input  logic [7:0] payload_6_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] data_byte_o,
  output logic [7:0] byte_offset_o,
  output logic [2:0] status_o,
  output logic       last_of_frame_o,
  output logic       message_done_o,
  output logic [8:0] total_bytes_o
);
  import csr_pkg::*;

  payload_t payload;
  job_t     front_job, back_job;
  logic     q_full, q_empty, q_pop, accept;
  result_t  res;

  assign payload = {payload_6_i, payload_5_i, payload_4_i, payload_3_i,
                    payload_2_i, payload_1_i, payload_0_i};
  assign full_o      = q_full;
  assign accept      = push_i && !q_full;
  assign cfg_ready_o = 1'b1;

  csr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .length_code_i (length_code_i),
    .header_byte_i (header_byte_i),
    .payload_i     (payload),
    .job_o         (front_job)
  );

  csr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push_i),
    .wr_job_i (front_job),
    .full_o   (q_full),
    .rd_i     (q_pop),
    .rd_job_o (back_job),
    .empty_o  (q_empty)
  );

  csr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_empty_i (q_empty),
    .job_pop_o   (q_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .res_o       (res)
  );

  assign data_byte_o     = res.data_byte;
  assign byte_offset_o   = res.byte_offset;
  assign status_o        = res.status;
  assign last_of_frame_o = res.last_of_frame;
  assign message_done_o  = res.message_done;
  assign total_bytes_o   = res.total_bytes;

`ifndef SYNTHESIS
  a_err_ends_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o != ST_DATA) |-> (last_of_frame_o && message_done_o))
    else $error("error result does not end the message");

  a_err_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o != ST_DATA) |-> (data_byte_o == 8'd0 && byte_offset_o == 8'd0))
    else $error("error result carries data");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && message_done_o) |-> last_of_frame_o)
    else $error("message done before end of frame");

  a_total_tracks_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o == ST_DATA) |-> (total_bytes_o[7:0] == byte_offset_o + 8'd1))
    else $error("total bytes out of step with offset");
`endif

endmodule
